>>> rtl/assert_macros.svh
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge, off while reset is asserted.
`define CHK_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`endif

>>> rtl/imrsz_pkg.sv
// ----------------------------------------------------------------------------
// imrsz_pkg
// Types and constants shared by the resize controller, the datapath and the
// top level.
// ----------------------------------------------------------------------------
package imrsz_pkg;

	localparam int SIZE_W  = 9;   // source height / width register
	localparam int SCALE_W = 24;  // Q8.16 scale
	localparam int T_W     = 37;  // (2*index+1)*scale
	localparam int FRAC_W  = 17;  // Q0.17 fraction
	localparam int WT_W    = 36;  // product of two axis weights
	localparam int PROD_W  = 52;  // weight times sample
	localparam int ACC_W   = 54;  // sum of four products
	localparam int SMP_W   = 16;
	localparam int CFG_AW  = 3;
	localparam int CFG_DW  = 24;

	localparam logic [T_W-1:0]    HALF_Q17 = T_W'(65536);
	localparam logic [FRAC_W:0]   ONE_Q17  = 18'h20000;
	localparam logic [ACC_W:0]    RND_Q34  = (ACC_W+1)'(64'h2_0000_0000);

	// request codes
	localparam logic REQ_WRITE = 1'b0;
	localparam logic REQ_READ  = 1'b1;

	// interpolation modes
	localparam logic MODE_NEAREST  = 1'b0;
	localparam logic MODE_BILINEAR = 1'b1;

	// register indexes
	localparam logic [CFG_AW-1:0] CFG_SRC_H = 3'd0;
	localparam logic [CFG_AW-1:0] CFG_SRC_W = 3'd1;
	localparam logic [CFG_AW-1:0] CFG_TGT_H = 3'd2;
	localparam logic [CFG_AW-1:0] CFG_TGT_W = 3'd3;
	localparam logic [CFG_AW-1:0] CFG_MODE  = 3'd4;
	localparam logic [CFG_AW-1:0] CFG_RSCL  = 3'd5;
	localparam logic [CFG_AW-1:0] CFG_CSCL  = 3'd6;

	typedef enum logic [3:0] {
		S_IDLE, S_MAP, S_AXIS, S_RD0, S_RD1, S_RD2, S_RD3, S_DR1, S_DR2, S_DONE
	} state_t;

	typedef struct packed {
		logic [SIZE_W-1:0]  src_h;
		logic [SIZE_W-1:0]  src_w;
		logic               mode;
		logic [SCALE_W-1:0] row_scale;
		logic [SCALE_W-1:0] col_scale;
	} cfg_t;

	// controller -> datapath
	typedef struct packed {
		logic       capture;   // input beat taken
		logic       map;       // form T on both axes
		logic       axis;      // neighbours and fractions, clear accumulator
		logic       rd;        // read one neighbour
		logic [1:0] rd_sel;    // {row neighbour, column neighbour}
		logic       out_load;  // move result into output register
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic req_read;
	} stat_t;

	typedef struct packed {
		logic [SIZE_W-1:0] i0;
		logic [SIZE_W-1:0] i1;
		logic [FRAC_W-1:0] f;
	} axis_t;

	function automatic logic [SIZE_W-1:0] clamp_idx(logic [20:0] v, logic [SIZE_W-1:0] size);
		logic [SIZE_W-1:0] r;
		if (v >= 21'(size)) r = size - SIZE_W'(1);
		else r = v[SIZE_W-1:0];
		return r;
	endfunction

	// Neighbour indices and fraction along one axis.
	function automatic axis_t axis_map(logic [T_W-1:0] t, logic [SIZE_W-1:0] size,
			logic bil);
		logic [T_W-1:0] s;
		axis_t a;
		s = t - HALF_Q17;
		if (bil == MODE_NEAREST) begin
			a.i0 = clamp_idx({1'b0, t[T_W-1:17]}, size);
			a.i1 = a.i0;
			a.f  = '0;
		end else if (t >= HALF_Q17) begin
			a.f  = s[FRAC_W-1:0];
			a.i0 = clamp_idx({1'b0, s[T_W-1:17]}, size);
			a.i1 = clamp_idx({1'b0, s[T_W-1:17]} + 21'd1, size);
		end else begin
			// floor is -1, both neighbours sit on index 0
			a.f  = t[FRAC_W-1:0] + HALF_Q17[FRAC_W-1:0];
			a.i0 = '0;
			a.i1 = '0;
		end
		return a;
	endfunction

endpackage

>>> rtl/imrsz_ctrl.sv
// ----------------------------------------------------------------------------
// imrsz_ctrl
// Sequencer for one item: map, neighbour reads, drain of the MAC pipe, and
// the output register handshake.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module imrsz_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  imrsz_pkg::stat_t  stat,
	output imrsz_pkg::cmd_t   cmd
);
	import imrsz_pkg::*;

	state_t state_q, state_nx;
	logic   out_valid_q;
	logic   slot_free;

	assign slot_free = !out_valid_q || out_ready;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_nx;
	end

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			S_IDLE: if (in_valid && stat.req_read) state_nx = S_MAP;
			S_MAP:  state_nx = S_AXIS;
			S_AXIS: state_nx = S_RD0;
			S_RD0:  state_nx = S_RD1;
			S_RD1:  state_nx = S_RD2;
			S_RD2:  state_nx = S_RD3;
			S_RD3:  state_nx = S_DR1;
			S_DR1:  state_nx = S_DR2;
			S_DR2:  state_nx = S_DONE;
			S_DONE: if (slot_free) state_nx = S_IDLE;
			default: state_nx = S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
			end
			S_MAP:  cmd.map = 1'b1;
			S_AXIS: cmd.axis = 1'b1;
			S_RD0: begin
				cmd.rd = 1'b1; cmd.rd_sel = 2'd0;
			end
			S_RD1: begin
				cmd.rd = 1'b1; cmd.rd_sel = 2'd1;
			end
			S_RD2: begin
				cmd.rd = 1'b1; cmd.rd_sel = 2'd2;
			end
			S_RD3: begin
				cmd.rd = 1'b1; cmd.rd_sel = 2'd3;
			end
			S_DONE: cmd.out_load = slot_free;
			default: cmd = '0;
		endcase
	end

	// output beat valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (cmd.out_load) out_valid_q <= 1'b1;
		else if (out_ready) out_valid_q <= 1'b0;
	end

	assign out_valid = out_valid_q;

	`CHK_ASSERT(a_load_free, clk, arst_n, cmd.out_load |-> (!out_valid_q || out_ready), "result overwrote a pending beat")
	`CHK_ASSERT(a_read_start, clk, arst_n, (in_valid && in_ready && stat.req_read) |=> (state_q == S_MAP), "read beat did not start the sequence")
	`CHK_ASSERT(a_rose_done, clk, arst_n, $rose(out_valid_q) |-> ($past(state_q) == S_DONE), "result appeared outside the done step")

endmodule

>>> rtl/imrsz_dp.sv
// ----------------------------------------------------------------------------
// imrsz_dp
// Frame memory, coordinate mapping, weight generation and the
// multiply-accumulate pipe with final rounding.
// ----------------------------------------------------------------------------
module imrsz_dp #(
	parameter int MAX_SRC_HEIGHT = 256,
	parameter int MAX_SRC_WIDTH  = 256,
	parameter int MAX_CHANNELS   = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  imrsz_pkg::cfg_t   cfg,
	input  imrsz_pkg::cmd_t   cmd,
	output imrsz_pkg::stat_t  stat,
	input  logic              req_type,
	input  logic [11:0]       pixel_row,
	input  logic [11:0]       pixel_col,
	input  logic [1:0]        pixel_channel,
	input  logic [15:0]       sample_in,
	output logic [15:0]       sample_out
);
	import imrsz_pkg::*;

	localparam int DEPTH = MAX_SRC_HEIGHT * MAX_SRC_WIDTH * MAX_CHANNELS;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [SIZE_W-1:0] eff_h, eff_w;
	logic              in_ch_ok, wr_en;
	logic [AW-1:0]     waddr, raddr;

	logic [11:0]       row_q, col_q;
	logic [1:0]        ch_q;
	logic              ch_ok_q;
	logic [T_W-1:0]    ty_q, tx_q;
	axis_t             ay, ax;
	logic [SIZE_W-1:0] y0_q, y1_q, x0_q, x1_q;
	logic [FRAC_W-1:0] fy_q, fx_q;

	logic [SIZE_W-1:0] yi, xi;
	logic [1:0]        chsel;
	logic [FRAC_W:0]   wy, wx;

	logic [SMP_W-1:0]  mem [DEPTH];
	logic [SMP_W-1:0]  rdata_s1;
	logic [WT_W-1:0]   wt_s1;
	logic              v_s1;
	logic [PROD_W-1:0] prod_s2;
	logic              v_s2;
	logic [ACC_W-1:0]  acc_q;
	logic [ACC_W:0]    rsum;
	logic [ACC_W-34:0] rnd;
	logic [SMP_W-1:0]  result;
	logic [SMP_W-1:0]  sample_q;

	// effective frame size: zero acts as one, clip to the memory size
	assign eff_h = (cfg.src_h == '0) ? SIZE_W'(1) :
		((13'(cfg.src_h) > 13'(MAX_SRC_HEIGHT)) ? SIZE_W'(MAX_SRC_HEIGHT) : cfg.src_h);
	assign eff_w = (cfg.src_w == '0) ? SIZE_W'(1) :
		((13'(cfg.src_w) > 13'(MAX_SRC_WIDTH)) ? SIZE_W'(MAX_SRC_WIDTH) : cfg.src_w);

	assign stat.req_read = (req_type == REQ_READ);

	// write path, taken on the input beat itself
	assign in_ch_ok = 3'(pixel_channel) < 3'(MAX_CHANNELS);
	assign wr_en = cmd.capture && (req_type == REQ_WRITE) && in_ch_ok &&
		(13'(pixel_row) < 13'(eff_h)) && (13'(pixel_col) < 13'(eff_w));
	assign waddr = AW'((AW'(pixel_row[SIZE_W-1:0]) * AW'(MAX_SRC_WIDTH)
		+ AW'(pixel_col[SIZE_W-1:0])) * AW'(MAX_CHANNELS) + AW'(pixel_channel));

	// item capture
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			row_q   <= pixel_row;
			col_q   <= pixel_col;
			ch_q    <= pixel_channel;
			ch_ok_q <= in_ch_ok;
		end
	end

	// T = (2*index+1)*scale on both axes
	always_ff @(posedge clk) begin
		if (cmd.map) begin
			ty_q <= T_W'({row_q, 1'b1}) * T_W'(cfg.row_scale);
			tx_q <= T_W'({col_q, 1'b1}) * T_W'(cfg.col_scale);
		end
	end

	// neighbours and fractions
	assign ay = axis_map(ty_q, eff_h, cfg.mode);
	assign ax = axis_map(tx_q, eff_w, cfg.mode);

	always_ff @(posedge clk) begin
		if (cmd.axis) begin
			y0_q <= ay.i0; y1_q <= ay.i1; fy_q <= ay.f;
			x0_q <= ax.i0; x1_q <= ax.i1; fx_q <= ax.f;
		end
	end

	// neighbour select and weights
	assign yi    = cmd.rd_sel[1] ? y1_q : y0_q;
	assign xi    = cmd.rd_sel[0] ? x1_q : x0_q;
	assign wy    = cmd.rd_sel[1] ? {1'b0, fy_q} : (ONE_Q17 - {1'b0, fy_q});
	assign wx    = cmd.rd_sel[0] ? {1'b0, fx_q} : (ONE_Q17 - {1'b0, fx_q});
	assign chsel = ch_ok_q ? ch_q : 2'd0;
	assign raddr = AW'((AW'(yi) * AW'(MAX_SRC_WIDTH) + AW'(xi)) * AW'(MAX_CHANNELS)
		+ AW'(chsel));

	// frame memory, one write or one read per cycle
	always_ff @(posedge clk) begin
		if (wr_en) mem[waddr] <= sample_in;
		if (cmd.rd) rdata_s1 <= mem[raddr];
	end

	// stage 1: weight product alongside the read
	always_ff @(posedge clk) begin
		if (cmd.rd) wt_s1 <= WT_W'(wy) * WT_W'(wx);
	end

	// stage 2: weight times sample
	always_ff @(posedge clk) begin
		if (v_s1) prod_s2 <= PROD_W'(wt_s1) * PROD_W'(rdata_s1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= cmd.rd;
			v_s2 <= v_s1;
		end
	end

	// accumulate the four terms
	always_ff @(posedge clk) begin
		if (cmd.axis) acc_q <= '0;
		else if (v_s2) acc_q <= acc_q + ACC_W'(prod_s2);
	end

	// round to nearest, saturate
	assign rsum   = (ACC_W+1)'(acc_q) + RND_Q34;
	assign rnd    = rsum[ACC_W:34];
	assign result = !ch_ok_q ? '0 :
		((|rnd[ACC_W-34:SMP_W]) ? {SMP_W{1'b1}} : rnd[SMP_W-1:0]);

	always_ff @(posedge clk) begin
		if (cmd.out_load) sample_q <= result;
	end

	assign sample_out = sample_q;

endmodule

>>> rtl/image_resize_bilinear_nearest.sv
// Image resize engine with a source frame store. A write beat stores one sample.
// A read beat keeps the input closed while the item is processed (coordinate
// multiply, neighbour mapping, four reads of the single-port frame memory,
// multiply-accumulate drain, result load), so no new beat is taken until the
// last read is through; its time is bounded by the four memory reads and the
// MAC pipe behind them. The result load waits while the output register still
// holds an unaccepted beat.
// The result waits in an output register while the next beat is taken. There is
// no clearing pass: reading an entry never written returns an undefined sample.
// ----------------------------------------------------------------------------
// image_resize_bilinear_nearest
// Top level: configuration registers, controller and datapath.
// ----------------------------------------------------------------------------
module image_resize_bilinear_nearest #(
	parameter int MAX_SRC_HEIGHT = 256,
	parameter int MAX_SRC_WIDTH  = 256,
	parameter int MAX_CHANNELS   = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_addr,
	input  logic [23:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        req_type,
	input  logic [11:0] pixel_row,
	input  logic [11:0] pixel_col,
	input  logic [1:0]  pixel_channel,
	input  logic [15:0] sample_in,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] sample_out
);
	import imrsz_pkg::*;

	cfg_t  cfg_q;
	cmd_t  cmd;
	stat_t stat;

	// configuration registers; target size is accepted and not used
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.src_h     <= SIZE_W'(256);
			cfg_q.src_w     <= SIZE_W'(256);
			cfg_q.mode      <= MODE_BILINEAR;
			cfg_q.row_scale <= SCALE_W'(65536);
			cfg_q.col_scale <= SCALE_W'(65536);
		end else if (cfg_we) begin
			case (cfg_addr)
				CFG_SRC_H: cfg_q.src_h     <= cfg_wdata[SIZE_W-1:0];
				CFG_SRC_W: cfg_q.src_w     <= cfg_wdata[SIZE_W-1:0];
				CFG_TGT_H, CFG_TGT_W: ;
				CFG_MODE:  cfg_q.mode      <= cfg_wdata[0];
				CFG_RSCL:  cfg_q.row_scale <= cfg_wdata[SCALE_W-1:0];
				CFG_CSCL:  cfg_q.col_scale <= cfg_wdata[SCALE_W-1:0];
				default: ;
			endcase
		end
	end

	imrsz_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	imrsz_dp #(
		.MAX_SRC_HEIGHT (MAX_SRC_HEIGHT),
		.MAX_SRC_WIDTH  (MAX_SRC_WIDTH),
		.MAX_CHANNELS   (MAX_CHANNELS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.cmd           (cmd),
		.stat          (stat),
		.req_type      (req_type),
		.pixel_row     (pixel_row),
		.pixel_col     (pixel_col),
		.pixel_channel (pixel_channel),
		.sample_in     (sample_in),
		.sample_out    (sample_out)
	);

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the image resize engine.
// Loads source samples, reads resized pixels in nearest and bilinear mode and
// compares every output beat with a bit-exact fixed-point predictor. Reads are
// only issued once every source sample they touch has been written.
// ----------------------------------------------------------------------------
module tb;
	import imrsz_pkg::*;

	localparam int FRAME_H    = 256;
	localparam int FRAME_W    = 256;
	localparam int CHANS      = 4;
	localparam int DEPTH      = FRAME_H * FRAME_W * CHANS;
	localparam int CYCLE_CAP  = 2000000;
	localparam int SETTLE     = 20;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_addr = '0;
	logic [23:0] cfg_wdata = '0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        req_type = 1'b0;
	logic [11:0] pixel_row = '0;
	logic [11:0] pixel_col = '0;
	logic [1:0]  pixel_channel = '0;
	logic [15:0] sample_in = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [15:0] sample_out;

	// mirrored configuration
	logic [8:0]  src_h_reg, src_w_reg;
	logic [12:0] tgt_h_reg, tgt_w_reg;
	logic        mode_reg;
	logic [23:0] rscale_reg, cscale_reg;

	// mirrored frame memory and which entries hold data
	logic [15:0] frame_mem [DEPTH];
	bit          frame_valid [DEPTH];

	logic [15:0] pending_samples [$];
	int          mismatches = 0;
	int          cycles = 0;
	bit          idle_on = 1'b1;
	int          hold_left = 0;
	int          stall_left = 0;

	image_resize_bilinear_nearest dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_ready(in_ready),
		.req_type(req_type), .pixel_row(pixel_row), .pixel_col(pixel_col),
		.pixel_channel(pixel_channel), .sample_in(sample_in),
		.out_valid(out_valid), .out_ready(out_ready), .sample_out(sample_out)
	);

	always #5 clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_CAP) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// ---------------- predictor ----------------
	function automatic int eff_dim(logic [8:0] v, int maxv);
		if (v == 0) return 1;
		return (v > maxv) ? maxv : int'(v);
	endfunction

	function automatic int clamp_to(logic [63:0] v, int sz);
		return (v >= sz) ? sz - 1 : int'(v);
	endfunction

	function automatic int mem_addr(int r, int c, int ch);
		return (r * FRAME_W + c) * CHANS + ch;
	endfunction

	// neighbors and Q0.17 fraction on one axis
	function automatic void split_axis(input logic [63:0] t, input int sz,
			output int i0, output int i1, output logic [63:0] f);
		logic [63:0] s;
		if (t >= 64'h10000) begin
			s  = t - 64'h10000;
			f  = s & 64'h1FFFF;
			i0 = clamp_to(s >> 17, sz);
			i1 = clamp_to((s >> 17) + 1, sz);
		end else begin
			f  = t + 64'h10000;
			i0 = 0;
			i1 = 0;
		end
	endfunction

	function automatic logic [63:0] row_t(logic [11:0] r);
		return (2 * 64'(r) + 1) * 64'(rscale_reg);
	endfunction

	function automatic logic [63:0] col_t(logic [11:0] c);
		return (2 * 64'(c) + 1) * 64'(cscale_reg);
	endfunction

	function automatic logic [15:0] resized_sample(logic [11:0] r, logic [11:0] c,
			logic [1:0] ch);
		int h, w, y0, y1, x0, x1;
		logic [63:0] fy, fx, acc, res, one;
		h   = eff_dim(src_h_reg, FRAME_H);
		w   = eff_dim(src_w_reg, FRAME_W);
		one = 64'h20000;
		if (mode_reg == MODE_NEAREST)
			return frame_mem[mem_addr(clamp_to(row_t(r) >> 17, h),
				clamp_to(col_t(c) >> 17, w), ch)];
		split_axis(row_t(r), h, y0, y1, fy);
		split_axis(col_t(c), w, x0, x1, fx);
		acc = (one - fy) * (one - fx) * frame_mem[mem_addr(y0, x0, ch)]
			+ (one - fy) * fx * frame_mem[mem_addr(y0, x1, ch)]
			+ fy * (one - fx) * frame_mem[mem_addr(y1, x0, ch)]
			+ fy * fx * frame_mem[mem_addr(y1, x1, ch)];
		res = (acc + (64'd1 << 33)) >> 34;
		if (res > 64'hFFFF) res = 64'hFFFF;
		return res[15:0];
	endfunction

	// ---------------- stimulus ----------------
	// one input beat; the predictor is updated when the beat is taken
	task automatic send_beat(logic kind, logic [11:0] r, logic [11:0] c,
			logic [1:0] ch, logic [15:0] smp);
		if (idle_on && $urandom_range(0, 5) == 0) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
		req_type = kind;
		pixel_row = r;
		pixel_col = c;
		pixel_channel = ch;
		sample_in = smp;
		in_valid = 1'b1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		if (kind == REQ_WRITE) begin
			if (r < eff_dim(src_h_reg, FRAME_H) && c < eff_dim(src_w_reg, FRAME_W)) begin
				frame_mem[mem_addr(r, c, ch)] = smp;
				frame_valid[mem_addr(r, c, ch)] = 1'b1;
			end
		end else begin
			pending_samples.push_back(resized_sample(r, c, ch));
		end
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	task automatic fill_if_blank(int r, int c, logic [1:0] ch);
		if (!frame_valid[mem_addr(r, c, ch)])
			send_beat(REQ_WRITE, 12'(r), 12'(c), ch, 16'($urandom));
	endtask

	// read one pixel, loading any source sample it would touch first
	task automatic read_pixel(logic [11:0] r, logic [11:0] c, logic [1:0] ch);
		int h, w, y0, y1, x0, x1;
		logic [63:0] fy, fx;
		h = eff_dim(src_h_reg, FRAME_H);
		w = eff_dim(src_w_reg, FRAME_W);
		if (mode_reg == MODE_NEAREST) begin
			fill_if_blank(clamp_to(row_t(r) >> 17, h), clamp_to(col_t(c) >> 17, w), ch);
		end else begin
			split_axis(row_t(r), h, y0, y1, fy);
			split_axis(col_t(c), w, x0, x1, fx);
			fill_if_blank(y0, x0, ch);
			fill_if_blank(y0, x1, ch);
			fill_if_blank(y1, x0, ch);
			fill_if_blank(y1, x1, ch);
		end
		send_beat(REQ_READ, r, c, ch, 16'($urandom));
	endtask

	// sender stops until every expected sample is back
	task automatic drain;
		while (pending_samples.size() != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic reg_write(logic [2:0] idx, logic [23:0] val);
		cfg_we = 1'b1;
		cfg_addr = idx;
		cfg_wdata = val;
		@(negedge clk);
		cfg_we = 1'b0;
		case (idx)
			CFG_SRC_H: src_h_reg = val[8:0];
			CFG_SRC_W: src_w_reg = val[8:0];
			CFG_TGT_H: tgt_h_reg = val[12:0];
			CFG_TGT_W: tgt_w_reg = val[12:0];
			CFG_MODE:  mode_reg = val[0];
			CFG_RSCL:  rscale_reg = val;
			CFG_CSCL:  cscale_reg = val;
			default: ;
		endcase
	endtask

	task automatic setup(int sh, int sw, int th, int tw, logic md, int rs, int cs);
		drain();
		reg_write(CFG_SRC_H, 24'(sh));
		reg_write(CFG_SRC_W, 24'(sw));
		reg_write(CFG_TGT_H, 24'(th));
		reg_write(CFG_TGT_W, 24'(tw));
		reg_write(CFG_MODE, 24'(md));
		reg_write(CFG_RSCL, 24'(rs));
		reg_write(CFG_CSCL, 24'(cs));
	endtask

	function automatic int pick_size();
		case ($urandom_range(0, 9))
			0: return 0;
			1: return 256;
			2: return 511;
			default: return $urandom_range(1, 12);
		endcase
	endfunction

	function automatic int pick_scale(int s, int t);
		case ($urandom_range(0, 7))
			0: return 0;
			1: return 24'hFFFFFF;
			2: return $urandom_range(1, 24'hFFFFFF);
			default: return ((eff_dim(9'(s), 256) << 16) / t);
		endcase
	endfunction

	// ---------------- tests ----------------
	task automatic test_reset_defaults;
		src_h_reg = 9'd256; src_w_reg = 9'd256;
		tgt_h_reg = 13'd256; tgt_w_reg = 13'd256;
		mode_reg = MODE_BILINEAR;
		rscale_reg = 24'h010000; cscale_reg = 24'h010000;
		send_beat(REQ_WRITE, 12'd0, 12'd0, 2'd0, 16'h0000);
		send_beat(REQ_WRITE, 12'd0, 12'd1, 2'd0, 16'hFFFF);
		send_beat(REQ_WRITE, 12'd4095, 12'd4095, 2'd3, 16'hAAAA); // out of frame
		send_beat(REQ_WRITE, 12'd256, 12'd0, 2'd1, 16'h5555);     // out of frame
		for (int ch = 0; ch < CHANS; ch++) begin
			read_pixel(12'd0, 12'd0, 2'(ch));
			read_pixel(12'd255, 12'd255, 2'(ch));
		end
		read_pixel(12'd4095, 12'd4095, 2'd2);  // beyond target size
		read_pixel(12'd0, 12'd4095, 2'd1);
	endtask

	task automatic test_nearest_edges;
		setup(4, 5, 8, 3, MODE_NEAREST, (4 << 16) / 8, (5 << 16) / 3);
		for (int i = 0; i < 4; i++) read_pixel(12'(i * 3), 12'(i), 2'(i));
		setup(3, 3, 4096, 1, MODE_NEAREST, 0, 24'hFFFFFF);  // zero and max scale
		read_pixel(12'd0, 12'd0, 2'd0);
		read_pixel(12'd4095, 12'd4095, 2'd3);
		setup(0, 511, 1, 4096, MODE_BILINEAR, 24'hFFFFFF, 1);  // size limits
		send_beat(REQ_WRITE, 12'd1, 12'd0, 2'd0, 16'h1234);      // row outside
		read_pixel(12'd4095, 12'd0, 2'd0);
		read_pixel(12'd7, 12'd4095, 2'd3);
	endtask

	task automatic test_backpressure;
		setup(6, 6, 12, 12, MODE_BILINEAR, 32768, 32768);
		@(posedge clk);
		hold_left = 400;
		@(negedge clk);
		for (int i = 0; i < 40; i++)
			read_pixel(12'($urandom_range(0, 11)), 12'($urandom_range(0, 11)),
				2'($urandom_range(0, 3)));
		drain();
	endtask

	task automatic test_random(int phases, int per_phase);
		int sh, sw, th, tw;
		for (int p = 0; p < phases; p++) begin
			sh = pick_size(); sw = pick_size();
			th = $urandom_range(1, 4096); tw = $urandom_range(1, 4096);
			if ($urandom_range(0, 2) != 0) begin
				th = $urandom_range(1, 24); tw = $urandom_range(1, 24);
			end
			setup(sh, sw, th, tw, 1'($urandom_range(0, 1)),
				pick_scale(sh, th), pick_scale(sw, tw));
			if (p == phases - 1) idle_on = 1'b0;
			for (int i = 0; i < per_phase; i++) begin
				if ($urandom_range(0, 9) < 4)
					send_beat(REQ_WRITE, 12'($urandom_range(0, 15)),
						12'($urandom_range(0, 15)), 2'($urandom), 16'($urandom));
				else if ($urandom_range(0, 4) == 0)
					read_pixel(12'($urandom), 12'($urandom), 2'($urandom));
				else
					read_pixel(12'($urandom_range(0, th - 1)),
						12'($urandom_range(0, tw - 1)), 2'($urandom));
			end
		end
	endtask

	// ---------------- result side ----------------
	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else if (idle_on && $urandom_range(0, 7) == 0) begin
			stall_left = $urandom_range(0, 5);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// compare each output beat with the oldest prediction
	always @(posedge clk) begin
		logic [15:0] want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_samples.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected output beat: sample_out=%h", sample_out);
			end else begin
				want = pending_samples.pop_front();
				if (sample_out !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("sample_out mismatch: expected %h got %h", want, sample_out);
				end
			end
		end
	end

	initial begin
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_reset_defaults();
		test_nearest_edges();
		test_backpressure();
		test_random(12, 110);
		drain();
		if (mismatches == 0 && pending_samples.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
